@@ design/eatq_pkg.sv @@
// ============================================================================
// eatq_pkg
// Types and constants for the Euler-angle to quaternion converter: payload
// structs, fixed-point formats and the CORDIC arctangent table.
// ============================================================================
package eatq_pkg;

    localparam int ATAN_ENTRIES = 20;
    localparam int FRAC_Q30     = 30;
    localparam int ROUND_SHIFT  = 16;

    // lane order inside a pipeline stage
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    typedef logic signed [15:0] angle_t;      // Q4.12 radians
    typedef logic signed [15:0] quat_comp_t;  // Q1.14
    typedef logic signed [31:0] q30_t;        // Q.30 cordic x and y
    typedef logic signed [31:0] q28_t;        // Q.28 angle accumulator
    typedef logic signed [32:0] comp_sum_t;   // sum of two Q.30 triple products

    typedef struct packed {
        angle_t angle_about_x;
        angle_t angle_about_y;
        angle_t angle_about_z;
    } angles_t;

    typedef struct packed {
        quat_comp_t quat_w;
        quat_comp_t quat_x;
        quat_comp_t quat_y;
        quat_comp_t quat_z;
    } quat_t;

    typedef struct packed {
        q30_t x;
        q30_t y;
        q28_t z;
        logic flip;
    } cordic_lane_t;

    typedef cordic_lane_t [2:0] cordic_stage_t;

    typedef struct packed {
        q30_t cos_v;
        q30_t sin_v;
    } sincos_t;

    typedef sincos_t [2:0] sincos_stage_t;

    localparam q30_t GAIN_Q30         = 32'sd652032874;
    localparam q28_t PI_Q28           = 32'sd843314857;
    localparam q28_t HALF_PI_Q28      = 32'sd421657429;
    localparam q28_t NEG_HALF_PI_Q28  = -32'sd421657429;
    localparam logic signed [33:0] ROUND_HALF = 34'sd32768;
    localparam logic signed [17:0] ONE_Q14    = 18'sd16384;
    localparam logic signed [17:0] NEG_ONE_Q14 = -18'sd16384;

    // atan(2^-i) in Q.28, rounded to nearest
    localparam q28_t ATAN_Q28 [ATAN_ENTRIES] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512
    };

endpackage

@@ design/eatq_stream_if.sv @@
// ============================================================================
// eatq_stream_if
// Valid/ready channel carrying one payload struct per item.
// ============================================================================
interface eatq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

@@ design/euler_angles_to_quaternion_unit.sv @@
// ============================================================================
// euler_angles_to_quaternion_unit
// Converts x/y/z rotation angles to a unit quaternion: half-angle sine and
// cosine by pipelined CORDIC, then products and sums, rounded and saturated.
// ============================================================================
//
//  channel   dir   payload                                   format
//  --------  ----  ----------------------------------------  -------------
//  angles    in    angle_about_x, angle_about_y, angle_about_z  Q4.12 signed
//  quat      out   quat_w, quat_x, quat_y, quat_z             Q1.14 signed
//
//  one item per cycle while quat does not stall; the registered stages in order
//  are fold, one cordic iteration per stage, unfold, pair multiply, triple
//  multiply, sum, round and saturate
//  every stage has its own valid bit; a stage loads when it is empty or its
//  successor loads, so bubbles collapse and a stall on quat backs up stage by
//  stage without losing or repeating an item
//  reset clears the valid bits only
//
module euler_angles_to_quaternion_unit #(
    parameter int CORDIC_STAGES = 14
) (
    input  logic          clk,
    input  logic          rst_n,
    eatq_stream_if.sink   angles,
    eatq_stream_if.source quat
);

    localparam int S_UNF  = CORDIC_STAGES + 1;
    localparam int S_PAIR = CORDIC_STAGES + 2;
    localparam int S_TRI  = CORDIC_STAGES + 3;
    localparam int S_SUM  = CORDIC_STAGES + 4;
    localparam int S_OUT  = CORDIC_STAGES + 5;

    // ------------------------------------------------------------------
    // stage control
    // ------------------------------------------------------------------
    logic [S_OUT:0] vld_reg;
    logic [S_OUT:0] vld_next;
    logic [S_OUT:0] accept;

    always_comb
    begin
        accept[S_OUT] = !vld_reg[S_OUT] || quat.ready;
        for (int k = S_OUT - 1; k >= 0; k--)
        begin
            accept[k] = !vld_reg[k] || accept[k + 1];
        end
        vld_next[0] = angles.valid;
        for (int k = 1; k <= S_OUT; k++)
        begin
            vld_next[k] = vld_reg[k - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k <= S_OUT; k++)
            begin
                if (accept[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign angles.ready = accept[0];

    // ------------------------------------------------------------------
    // stage 0: halve and fold each angle into [-pi/2, pi/2]
    // ------------------------------------------------------------------
    eatq_pkg::cordic_stage_t cord_reg  [0:CORDIC_STAGES];
    eatq_pkg::cordic_stage_t cord_next [0:CORDIC_STAGES];
    eatq_pkg::angle_t        in_angle  [3];

    assign in_angle[eatq_pkg::LANE_X] = angles.data.angle_about_x;
    assign in_angle[eatq_pkg::LANE_Y] = angles.data.angle_about_y;
    assign in_angle[eatq_pkg::LANE_Z] = angles.data.angle_about_z;

    always_comb
    begin
        eatq_pkg::q28_t half;
        for (int l = 0; l < 3; l++)
        begin
            // angle << 15 is the half angle in Q.28
            half = {in_angle[l][15], in_angle[l], 15'b0};
            cord_next[0][l].x = eatq_pkg::GAIN_Q30;
            cord_next[0][l].y = '0;
            if (half > eatq_pkg::HALF_PI_Q28)
            begin
                cord_next[0][l].z    = half - eatq_pkg::PI_Q28;
                cord_next[0][l].flip = 1'b1;
            end
            else if (half < eatq_pkg::NEG_HALF_PI_Q28)
            begin
                cord_next[0][l].z    = half + eatq_pkg::PI_Q28;
                cord_next[0][l].flip = 1'b1;
            end
            else
            begin
                cord_next[0][l].z    = half;
                cord_next[0][l].flip = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept[0])
        begin
            cord_reg[0] <= cord_next[0];
        end
    end

    // ------------------------------------------------------------------
    // stages 1..CORDIC_STAGES: one rotation per stage, three lanes
    // ------------------------------------------------------------------
    for (genvar g = 1; g <= CORDIC_STAGES; g++)
    begin : g_cordic
        always_comb
        begin
            eatq_pkg::q30_t dx;
            eatq_pkg::q30_t dy;
            for (int l = 0; l < 3; l++)
            begin
                dx = $signed(cord_reg[g - 1][l].y) >>> (g - 1);
                dy = $signed(cord_reg[g - 1][l].x) >>> (g - 1);
                cord_next[g][l].flip = cord_reg[g - 1][l].flip;
                if (!cord_reg[g - 1][l].z[31])
                begin
                    cord_next[g][l].x = cord_reg[g - 1][l].x - dx;
                    cord_next[g][l].y = cord_reg[g - 1][l].y + dy;
                    cord_next[g][l].z = cord_reg[g - 1][l].z - eatq_pkg::ATAN_Q28[g - 1];
                end
                else
                begin
                    cord_next[g][l].x = cord_reg[g - 1][l].x + dx;
                    cord_next[g][l].y = cord_reg[g - 1][l].y - dy;
                    cord_next[g][l].z = cord_reg[g - 1][l].z + eatq_pkg::ATAN_Q28[g - 1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (accept[g])
            begin
                cord_reg[g] <= cord_next[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // unfold: negate sine and cosine for folded angles
    // ------------------------------------------------------------------
    eatq_pkg::sincos_stage_t sc_reg;
    eatq_pkg::sincos_stage_t sc_next;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (cord_reg[CORDIC_STAGES][l].flip)
            begin
                sc_next[l].cos_v = -cord_reg[CORDIC_STAGES][l].x;
                sc_next[l].sin_v = -cord_reg[CORDIC_STAGES][l].y;
            end
            else
            begin
                sc_next[l].cos_v = cord_reg[CORDIC_STAGES][l].x;
                sc_next[l].sin_v = cord_reg[CORDIC_STAGES][l].y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept[S_UNF])
        begin
            sc_reg <= sc_next;
        end
    end

    // ------------------------------------------------------------------
    // pair products of the y and z terms, x terms carried along
    // ------------------------------------------------------------------
    eatq_pkg::q30_t pcc_reg, pss_reg, psc_reg, pcs_reg, cx_reg, sx_reg;
    eatq_pkg::q30_t pcc_next, pss_next, psc_next, pcs_next;
    logic signed [63:0] prod_cc, prod_ss, prod_sc, prod_cs;

    assign prod_cc = sc_reg[eatq_pkg::LANE_Y].cos_v * sc_reg[eatq_pkg::LANE_Z].cos_v;
    assign prod_ss = sc_reg[eatq_pkg::LANE_Y].sin_v * sc_reg[eatq_pkg::LANE_Z].sin_v;
    assign prod_sc = sc_reg[eatq_pkg::LANE_Y].sin_v * sc_reg[eatq_pkg::LANE_Z].cos_v;
    assign prod_cs = sc_reg[eatq_pkg::LANE_Y].cos_v * sc_reg[eatq_pkg::LANE_Z].sin_v;

    // floor back to Q.30
    assign pcc_next = prod_cc[61:30];
    assign pss_next = prod_ss[61:30];
    assign psc_next = prod_sc[61:30];
    assign pcs_next = prod_cs[61:30];

    always_ff @(posedge clk)
    begin
        if (accept[S_PAIR])
        begin
            pcc_reg <= pcc_next;
            pss_reg <= pss_next;
            psc_reg <= psc_next;
            pcs_reg <= pcs_next;
            cx_reg  <= sc_reg[eatq_pkg::LANE_X].cos_v;
            sx_reg  <= sc_reg[eatq_pkg::LANE_X].sin_v;
        end
    end

    // ------------------------------------------------------------------
    // triple products
    // ------------------------------------------------------------------
    eatq_pkg::q30_t     tri_reg  [8];
    eatq_pkg::q30_t     tri_next [8];
    logic signed [63:0] tri_prod [8];

    assign tri_prod[0] = pcc_reg * cx_reg;   // w terms
    assign tri_prod[1] = pss_reg * sx_reg;
    assign tri_prod[2] = pcc_reg * sx_reg;   // x terms
    assign tri_prod[3] = pss_reg * cx_reg;
    assign tri_prod[4] = psc_reg * cx_reg;   // y terms
    assign tri_prod[5] = pcs_reg * sx_reg;
    assign tri_prod[6] = pcs_reg * cx_reg;   // z terms
    assign tri_prod[7] = psc_reg * sx_reg;

    always_comb
    begin
        for (int t = 0; t < 8; t++)
        begin
            tri_next[t] = tri_prod[t][61:30];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept[S_TRI])
        begin
            tri_reg <= tri_next;
        end
    end

    // ------------------------------------------------------------------
    // component sums
    // ------------------------------------------------------------------
    eatq_pkg::comp_sum_t sum_reg  [4];
    eatq_pkg::comp_sum_t sum_next [4];

    assign sum_next[0] = 33'(tri_reg[0]) + 33'(tri_reg[1]);
    assign sum_next[1] = 33'(tri_reg[2]) - 33'(tri_reg[3]);
    assign sum_next[2] = 33'(tri_reg[4]) + 33'(tri_reg[5]);
    assign sum_next[3] = 33'(tri_reg[6]) - 33'(tri_reg[7]);

    always_ff @(posedge clk)
    begin
        if (accept[S_SUM])
        begin
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // round to Q1.14 and saturate to plus or minus one
    // ------------------------------------------------------------------
    function automatic eatq_pkg::quat_comp_t round_sat(input eatq_pkg::comp_sum_t s);
        logic signed [33:0] rnd;
        logic signed [17:0] q;
        rnd = $signed({s[32], s}) + eatq_pkg::ROUND_HALF;
        q   = rnd[33:16];
        if (q > eatq_pkg::ONE_Q14)
        begin
            q = eatq_pkg::ONE_Q14;
        end
        else if (q < eatq_pkg::NEG_ONE_Q14)
        begin
            q = eatq_pkg::NEG_ONE_Q14;
        end
        return q[15:0];
    endfunction

    eatq_pkg::quat_t out_reg;
    eatq_pkg::quat_t out_next;

    assign out_next.quat_w = round_sat(sum_reg[0]);
    assign out_next.quat_x = round_sat(sum_reg[1]);
    assign out_next.quat_y = round_sat(sum_reg[2]);
    assign out_next.quat_z = round_sat(sum_reg[3]);

    always_ff @(posedge clk)
    begin
        if (accept[S_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign quat.valid = vld_reg[S_OUT];
    assign quat.data  = out_reg;

endmodule

@@ verif/tb_euler_angles_to_quaternion_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_euler_angles_to_quaternion_unit
// Streams angle triples into the converter and checks every quaternion
// against a bit-exact fixed-point CORDIC model, with random idle gaps on the
// angles side and random stalls on the quaternion side.
// ============================================================================
module tb_euler_angles_to_quaternion_unit;

    localparam int  STAGES       = 14;
    localparam int  LATENCY      = STAGES + 6;
    localparam int  IDLE_LIMIT   = 2000;
    localparam int  MAX_PRINTED  = 40;

    localparam longint CORDIC_GAIN     = 64'sd652032874;
    localparam longint PI_RAD_Q28      = 64'sd843314857;
    localparam longint HALF_PI_RAD_Q28 = 64'sd421657429;
    localparam longint UNIT_Q14        = 64'sd16384;
    localparam int     ATAN_STEPS      = 20;

    // arctangent of 2^-i, Q.28
    localparam longint ATAN_STEP_Q28 [ATAN_STEPS] = '{
        64'sd210828714, 64'sd124459457, 64'sd65760959, 64'sd33381290,
        64'sd16755422,  64'sd8385879,   64'sd4193963,  64'sd2097109,
        64'sd1048571,   64'sd524287,    64'sd262144,   64'sd131072,
        64'sd65536,     64'sd32768,     64'sd16384,    64'sd8192,
        64'sd4096,      64'sd2048,      64'sd1024,     64'sd512
    };

    // angle codes in Q4.12
    localparam eatq_pkg::angle_t ANG_PI     = 16'sd12868;
    localparam eatq_pkg::angle_t ANG_TWO_PI = 16'sd25736;
    localparam eatq_pkg::angle_t ANG_MAX    = 16'sd32767;
    localparam eatq_pkg::angle_t ANG_MIN    = -16'sd32768;

    logic clk;
    logic rst_n;

    eatq_stream_if #(.payload_t(eatq_pkg::angles_t)) angles_if ();
    eatq_stream_if #(.payload_t(eatq_pkg::quat_t))   quat_if ();

    euler_angles_to_quaternion_unit #(
        .CORDIC_STAGES(STAGES)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angles_if),
        .quat   (quat_if)
    );

    eatq_pkg::quat_t expected_quats [$];
    int    error_count;
    int    triples_sent;
    int    quats_checked;
    int    idle_cycles;
    bit    tx_idle_en;
    bit    rx_stall_en;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // fixed-point prediction
    // ------------------------------------------------------------------------
    function automatic void half_angle_sincos(input eatq_pkg::angle_t a, output longint c,
                                              output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(a) * 32768;
        x = CORDIC_GAIN;
        y = 0;
        flip = 1'b0;
        // fold into [-pi/2, pi/2], sign of both outputs flips
        if (z > HALF_PI_RAD_Q28)
        begin
            z = z - PI_RAD_Q28;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_RAD_Q28)
        begin
            z = z + PI_RAD_Q28;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < ATAN_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP_Q28[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP_Q28[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint triple_product(input longint a, input longint b,
                                              input longint d);
        return (((a * b) >>> 30) * d) >>> 30;
    endfunction

    function automatic eatq_pkg::quat_comp_t round_sat_q14(input longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > UNIT_Q14)
            r = UNIT_Q14;
        if (r < -UNIT_Q14)
            r = -UNIT_Q14;
        return eatq_pkg::quat_comp_t'(r);
    endfunction

    function automatic eatq_pkg::quat_t quat_from_angles(input eatq_pkg::angles_t a);
        longint cx, sx, cy, sy, cz, sz;
        eatq_pkg::quat_t q;
        half_angle_sincos(a.angle_about_x, cx, sx);
        half_angle_sincos(a.angle_about_y, cy, sy);
        half_angle_sincos(a.angle_about_z, cz, sz);
        q.quat_w = round_sat_q14(triple_product(cy, cz, cx) + triple_product(sy, sz, sx));
        q.quat_x = round_sat_q14(triple_product(cy, cz, sx) - triple_product(sy, sz, cx));
        q.quat_y = round_sat_q14(triple_product(sy, cz, cx) + triple_product(cy, sz, sx));
        q.quat_z = round_sat_q14(triple_product(cy, sz, cx) - triple_product(sy, cz, sx));
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic eatq_pkg::angle_t random_angle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return eatq_pkg::angle_t'($urandom_range(0, 2 * ANG_TWO_PI) - ANG_TWO_PI);
        if (r < 80)
            return eatq_pkg::angle_t'($urandom());
        // hug the quadrant fold at +-pi
        if (r < 90)
            return eatq_pkg::angle_t'(($urandom_range(0, 1) ? ANG_PI : -ANG_PI)
                                      + $urandom_range(0, 8) - 4);
        case ($urandom_range(0, 4))
            0: return 16'sd0;
            1: return ANG_MAX;
            2: return ANG_MIN;
            3: return ANG_TWO_PI;
            default: return -ANG_TWO_PI;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // record the prediction when an angle item is taken
    always @(posedge clk)
    begin
        if (rst_n && angles_if.valid && angles_if.ready)
        begin
            expected_quats.push_back(quat_from_angles(angles_if.data));
            triples_sent++;
        end
    end

    always @(posedge clk)
    begin
        eatq_pkg::quat_t got;
        eatq_pkg::quat_t want;
        if (rst_n && quat_if.valid && quat_if.ready)
        begin
            got = quat_if.data;
            if (expected_quats.size() == 0)
            begin
                report_mismatch("unexpected quaternion item, w", got.quat_w, 0);
            end
            else
            begin
                want = expected_quats.pop_front();
                quats_checked++;
                if (got.quat_w !== want.quat_w)
                    report_mismatch("quat_w", got.quat_w, want.quat_w);
                if (got.quat_x !== want.quat_x)
                    report_mismatch("quat_x", got.quat_x, want.quat_x);
                if (got.quat_y !== want.quat_y)
                    report_mismatch("quat_y", got.quat_y, want.quat_y);
                if (got.quat_z !== want.quat_z)
                    report_mismatch("quat_z", got.quat_z, want.quat_z);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((angles_if.valid && angles_if.ready) || (quat_if.valid && quat_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // quaternion side ready
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        quat_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = rx_stall_en ? pick_gap() : 0;
            if (n > 0)
            begin
                @(negedge clk);
                quat_if.ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            quat_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // angle side
    // ------------------------------------------------------------------------
    // valid stays high from one item to the next unless a gap is drawn
    task automatic send_triple(input eatq_pkg::angle_t ax, input eatq_pkg::angle_t ay,
                               input eatq_pkg::angle_t az);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            angles_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        angles_if.valid <= 1'b1;
        angles_if.data  <= '{angle_about_x: ax, angle_about_y: ay, angle_about_z: az};
        do
            @(posedge clk);
        while (!(angles_if.valid && angles_if.ready));
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_triple(random_angle(), random_angle(), random_angle());
    endtask

    // drop valid first so the last item is not taken again while waiting
    task automatic wait_drained();
        @(negedge clk);
        angles_if.valid <= 1'b0;
        while (expected_quats.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_range_extremes();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        send_triple(16'sd0, 16'sd0, 16'sd0);
        send_triple(ANG_MAX, 16'sd0, 16'sd0);
        send_triple(16'sd0, ANG_MAX, 16'sd0);
        send_triple(16'sd0, 16'sd0, ANG_MAX);
        send_triple(ANG_MIN, 16'sd0, 16'sd0);
        send_triple(16'sd0, ANG_MIN, 16'sd0);
        send_triple(16'sd0, 16'sd0, ANG_MIN);
        send_triple(ANG_MAX, ANG_MAX, ANG_MAX);
        send_triple(ANG_MIN, ANG_MIN, ANG_MIN);
        send_triple(ANG_TWO_PI, -ANG_TWO_PI, ANG_TWO_PI);
        send_triple(-ANG_TWO_PI, ANG_TWO_PI, -ANG_TWO_PI);
        send_triple(16'sd1, -16'sd1, 16'sd1);
        // beyond two pi, taken at face value
        send_triple(16'sd30000, -16'sd30000, 16'sd28000);
    endtask

    task automatic test_quadrant_fold();
        // half angle crosses pi/2 between these codes
        send_triple(ANG_PI, 16'sd0, 16'sd0);
        send_triple(ANG_PI - 16'sd1, 16'sd0, 16'sd0);
        send_triple(-ANG_PI, 16'sd0, 16'sd0);
        send_triple(-ANG_PI + 16'sd1, 16'sd0, 16'sd0);
        send_triple(16'sd0, ANG_PI, -ANG_PI);
        send_triple(16'sd0, ANG_PI - 16'sd1, -ANG_PI + 16'sd1);
        send_triple(ANG_PI, ANG_PI, ANG_PI);
        send_triple(-ANG_PI, -ANG_PI, -ANG_PI);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        send_random(300);
    endtask

    task automatic test_gaps_and_stalls();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        send_random(900);
    endtask

    task automatic test_pause_until_drained();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b1;
        send_random(100);
        wait_drained();
        tx_idle_en = 1'b1;
        send_random(100);
    endtask

    initial
    begin
        error_count   = 0;
        triples_sent  = 0;
        quats_checked = 0;
        idle_cycles   = 0;
        tx_idle_en    = 1'b0;
        rx_stall_en   = 1'b0;
        rst_n         = 1'b0;
        angles_if.valid = 1'b0;
        angles_if.data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_range_extremes();
        test_quadrant_fold();
        test_back_to_back();
        test_gaps_and_stalls();
        test_pause_until_drained();

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);

        $display("sent %0d angle triples (extremes, pi fold edges, random)", triples_sent);
        $display("checked %0d quaternions, back to back, with gaps and stalls, and drained",
                 quats_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
design/eatq_pkg.sv
design/eatq_stream_if.sv
design/euler_angles_to_quaternion_unit.sv
verif/tb_euler_angles_to_quaternion_unit.sv
